// ===== src/idle_cycle_load_monitor_top_assert.svh =====
// assertion macros shared by the load monitor modules
// needs a clock named clk and an active-low reset named arst_n in the using module
`ifndef IDLE_CYCLE_LOAD_MONITOR_TOP_ASSERT_SVH
`define IDLE_CYCLE_LOAD_MONITOR_TOP_ASSERT_SVH

// condition must hold on every clock edge outside reset
`define ICLM_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequence must hold in the same cycle as the antecedent
`define ICLM_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// consequence must hold in the cycle after the antecedent
`define ICLM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/iclm_pkg.sv =====
// types and constants of the idle-cycle load monitor
// no dependencies; used by iclm_div and idle_cycle_load_monitor_top
`default_nettype none

package iclm_pkg;

	// datapath widths
	typedef logic [31:0] dt_t;    // window length in ms, cycle counts, accumulators
	typedef logic [41:0] prod_t;  // ms times mhz
	typedef logic [51:0] win_t;   // window length in cycles
	typedef logic [59:0] num_t;   // dividend of either quotient
	typedef logic [64:0] dsh_t;   // divisor aligned to the top quotient bit
	typedef logic [13:0] quo_t;   // quotient, wide enough for idle hundredths
	typedef logic [3:0]  step_t;  // quotient bits still to go

	// input beat
	typedef struct packed {
		logic        op;
		logic        core;
		logic [31:0] cycle_count;
		logic [31:0] now_ms;
		logic [9:0]  cpu_mhz;
	} in_item_t;

	// output beat
	typedef struct packed {
		logic        out_core;
		logic [6:0]  load_percent;
		logic [13:0] idle_hundredths;
		logic        last;
	} out_item_t;

	// operation codes
	localparam logic OP_IDLE_EVENT = 1'b0;
	localparam logic OP_UPDATE     = 1'b1;

	// register indexes of the config port
	typedef enum logic [1:0] {
		REG_GAP_LIMIT  = 2'd0,
		REG_MIN_WINDOW = 2'd1
	} cfg_reg_t;

	localparam logic [31:0] GAP_LIMIT_RESET  = 32'd4800;
	localparam logic [15:0] MIN_WINDOW_RESET = 16'd500;

	// scale factors
	localparam int KHZ_PER_MHZ = 1000;   // cycles per ms per MHz
	localparam int IDLE_SCALE  = 10000;  // hundredths of a percent
	localparam int LOAD_SCALE  = 200;    // twice the percent scale, for half-up rounding
	localparam int LOAD_BIAS   = 201;    // LOAD_SCALE plus one window for the rounding term

	localparam logic [13:0] IDLE_FULL = 14'd10000;
	localparam logic [6:0]  LOAD_NONE = 7'd0;

	// quotient bits per division
	localparam step_t IDLE_STEPS = 4'd14;
	localparam step_t LOAD_STEPS = 4'd7;

	// divider handshake between sequencer and shared unit
	typedef struct packed {
		logic  start;
		step_t steps;
		num_t  num;
		dsh_t  dsh;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		quo_t quo;
	} div_rsp_t;

	// sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_MUL1,
		S_MUL2,
		S_CHECK,
		S_PREP_IDLE,
		S_DIV_IDLE,
		S_PREP_LOAD,
		S_DIV_LOAD,
		S_OUT
	} state_t;

endpackage

`default_nettype wire

// ===== src/iclm_div.sv =====
// shared restoring divider, one quotient bit per cycle
// depends on iclm_pkg and idle_cycle_load_monitor_top_assert.svh
`default_nettype none
`include "idle_cycle_load_monitor_top_assert.svh"

module iclm_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire iclm_pkg::div_req_t req,
	output iclm_pkg::div_rsp_t     rsp
);

	logic                busy_q;
	logic                done_q;
	iclm_pkg::step_t     cnt_q;
	iclm_pkg::num_t      rem_q;
	iclm_pkg::dsh_t      dsh_q;
	iclm_pkg::quo_t      quo_q;
	logic                fits;

	// divisor is pre-shifted so it only ever moves right
	assign fits = iclm_pkg::dsh_t'(rem_q) >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= req.steps;
		end else if (busy_q) begin
			cnt_q  <= cnt_q - iclm_pkg::step_t'(1);
			busy_q <= (cnt_q != iclm_pkg::step_t'(1));
			done_q <= (cnt_q == iclm_pkg::step_t'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num;
			dsh_q <= req.dsh;
			quo_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - dsh_q[$bits(iclm_pkg::num_t)-1:0];
			end
			quo_q <= {quo_q[$bits(iclm_pkg::quo_t)-2:0], fits};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

	`ICLM_ASSERT_IMPLIES(a_div_start_free, req.start, !busy_q, "divider started while busy")
	`ICLM_ASSERT_IMPLIES(a_div_count_live, busy_q, cnt_q != '0, "divider busy with no bits left")
	`ICLM_ASSERT_NEXT(a_div_done_pulse, done_q, !done_q, "divider done held longer than a cycle")

endmodule

`default_nettype wire

// ===== src/idle_cycle_load_monitor_top.sv =====
// top level of the per-core idle-cycle load monitor: sequencer, state and output register
// depends on iclm_pkg, iclm_div and idle_cycle_load_monitor_top_assert.svh
//
// channel   dir  handshake              payload
// in        in   in_valid / in_ready    in_data (iclm_pkg::in_item_t)
// out       out  out_valid / out_ready  out_data (iclm_pkg::out_item_t)
// cfg       in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// an idle event is accepted, then accumulated in the decode step; in_ready is back the cycle after
// an update runs decode, two multiplies and the window check, then per core the shared divider at
// one quotient bit per cycle (14 idle, 7 load), or skips it if its idle count covers the window
// reset clears accumulators, previous counts and the window start; config takes reset values
// a stalled out beat holds the next core's division at its output step; the last beat of
// an update can wait in the output register while new input beats are taken
// cfg writes are always taken (cfg_ready is tied high)
`default_nettype none
`include "idle_cycle_load_monitor_top_assert.svh"

module idle_cycle_load_monitor_top #(
	parameter int NUM_CORES = 2
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire iclm_pkg::in_item_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output iclm_pkg::out_item_t      out_data,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [31:0]         cfg_data
);

	localparam int CIDX_W = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;

	// config registers
	logic [31:0]              gap_q;
	logic [15:0]              minwin_q;

	// sequencer
	iclm_pkg::state_t         state_q, state_d;
	logic                     in_take;
	logic                     out_load;

	// latched input beat
	iclm_pkg::in_item_t       in_q;

	// per-core state and window start
	logic [31:0]              prev_q [NUM_CORES];
	logic [31:0]              idle_q [NUM_CORES];
	logic [31:0]              snap_q [NUM_CORES];
	logic [31:0]              wstart_q;

	// window arithmetic
	iclm_pkg::dt_t            dt_q;
	iclm_pkg::prod_t          prod_q;
	iclm_pkg::win_t           w_q;
	iclm_pkg::num_t           w201_q;

	// per-core result
	logic [CIDX_W-1:0]        cidx_q;
	logic [13:0]              idle_res_q;
	logic [6:0]               load_res_q;
	logic                     last_core;

	// output register
	logic                     out_valid_q;
	iclm_pkg::out_item_t      out_q;

	// shared divider
	iclm_pkg::div_req_t       div_req;
	iclm_pkg::div_rsp_t       div_rsp;

	// event and update decode
	logic                     core_ok;
	logic [CIDX_W-1:0]        ev_idx;
	logic [31:0]              delta;
	logic                     delta_ok;
	iclm_pkg::dt_t            dt;
	logic                     win_ok;
	logic [31:0]              cur_snap;
	logic                     snap_ge_w;
	iclm_pkg::num_t           idle_num;
	iclm_pkg::num_t           load_num;

	// core field is one bit wide, so only core 1 can be out of range
	assign core_ok  = (NUM_CORES > 1) || (in_q.core == 1'b0);
	assign ev_idx   = CIDX_W'(in_q.core);
	assign delta    = in_q.cycle_count - prev_q[ev_idx];
	assign delta_ok = delta < gap_q;

	// wrapping window length in ms
	assign dt     = in_q.now_ms - wstart_q;
	assign win_ok = dt >= iclm_pkg::dt_t'(minwin_q);

	assign cur_snap  = snap_q[cidx_q];
	assign snap_ge_w = iclm_pkg::win_t'(cur_snap) >= w_q;

	// idle dividend 10000*I; load dividend 200*(W-I)+W folded into 201*W - 200*I
	assign idle_num = iclm_pkg::num_t'(cur_snap) * iclm_pkg::num_t'(iclm_pkg::IDLE_SCALE);
	assign load_num = w201_q
		- iclm_pkg::num_t'(cur_snap) * iclm_pkg::num_t'(iclm_pkg::LOAD_SCALE);

	assign last_core = (cidx_q == CIDX_W'(NUM_CORES - 1));

	// divider request: idle over W with 14 bits, load over 2W with 7 bits
	always_comb begin
		div_req.start = 1'b0;
		div_req.steps = iclm_pkg::IDLE_STEPS;
		div_req.num   = idle_num;
		div_req.dsh   = {w_q, 13'b0};
		case (state_q)
			iclm_pkg::S_PREP_IDLE: begin
				div_req.start = !snap_ge_w;
			end
			iclm_pkg::S_PREP_LOAD: begin
				div_req.start = 1'b1;
				div_req.steps = iclm_pkg::LOAD_STEPS;
				div_req.num   = load_num;
				div_req.dsh   = {6'b0, w_q, 7'b0};
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	iclm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iclm_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handshake outputs
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		out_load = 1'b0;
		case (state_q)
			iclm_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = iclm_pkg::S_DECODE;
				end
			end
			iclm_pkg::S_DECODE: begin
				if (in_q.op == iclm_pkg::OP_UPDATE && win_ok) begin
					state_d = iclm_pkg::S_MUL1;
				end else begin
					state_d = iclm_pkg::S_IDLE;
				end
			end
			iclm_pkg::S_MUL1: begin
				state_d = iclm_pkg::S_MUL2;
			end
			iclm_pkg::S_MUL2: begin
				state_d = iclm_pkg::S_CHECK;
			end
			iclm_pkg::S_CHECK: begin
				// zero-length window in cycles (zero clock): restart only, no beats
				if (w_q == '0) begin
					state_d = iclm_pkg::S_IDLE;
				end else begin
					state_d = iclm_pkg::S_PREP_IDLE;
				end
			end
			iclm_pkg::S_PREP_IDLE: begin
				if (snap_ge_w) begin
					state_d = iclm_pkg::S_OUT;
				end else begin
					state_d = iclm_pkg::S_DIV_IDLE;
				end
			end
			iclm_pkg::S_DIV_IDLE: begin
				if (div_rsp.done) begin
					state_d = iclm_pkg::S_PREP_LOAD;
				end
			end
			iclm_pkg::S_PREP_LOAD: begin
				state_d = iclm_pkg::S_DIV_LOAD;
			end
			iclm_pkg::S_DIV_LOAD: begin
				if (div_rsp.done) begin
					state_d = iclm_pkg::S_OUT;
				end
			end
			iclm_pkg::S_OUT: begin
				out_load = !out_valid_q || out_ready;
				if (out_load) begin
					state_d = last_core ? iclm_pkg::S_IDLE : iclm_pkg::S_PREP_IDLE;
				end
			end
			default: begin
				state_d = iclm_pkg::S_IDLE;
			end
		endcase
	end

	assign in_take = in_valid && in_ready;

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q       <= iclm_pkg::GAP_LIMIT_RESET;
			minwin_q    <= iclm_pkg::MIN_WINDOW_RESET;
			wstart_q    <= '0;
			cidx_q      <= '0;
			out_valid_q <= 1'b0;
			for (int c = 0; c < NUM_CORES; c++) begin
				prev_q[c] <= '0;
				idle_q[c] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					iclm_pkg::REG_GAP_LIMIT:  gap_q    <= cfg_data;
					iclm_pkg::REG_MIN_WINDOW: minwin_q <= cfg_data[15:0];
					default: ;
				endcase
			end

			if (state_q == iclm_pkg::S_DECODE) begin
				if (in_q.op == iclm_pkg::OP_IDLE_EVENT) begin
					// previous count of an in-range core always moves; long gaps count as preemption
					if (core_ok) begin
						prev_q[ev_idx] <= in_q.cycle_count;
						if (delta_ok) begin
							idle_q[ev_idx] <= idle_q[ev_idx] + delta;
						end
					end
				end else if (win_ok) begin
					wstart_q <= in_q.now_ms;
					for (int c = 0; c < NUM_CORES; c++) begin
						idle_q[c] <= '0;
					end
				end
			end

			if (state_q == iclm_pkg::S_CHECK) begin
				cidx_q <= '0;
			end else if (out_load && !last_core) begin
				cidx_q <= cidx_q + CIDX_W'(1);
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			in_q <= in_data;
		end

		if (state_q == iclm_pkg::S_DECODE && in_q.op == iclm_pkg::OP_UPDATE && win_ok) begin
			dt_q <= dt;
			for (int c = 0; c < NUM_CORES; c++) begin
				snap_q[c] <= idle_q[c];
			end
		end

		// one multiply per cycle: ms times mhz, then times 1000
		if (state_q == iclm_pkg::S_MUL1) begin
			prod_q <= iclm_pkg::prod_t'(dt_q) * iclm_pkg::prod_t'(in_q.cpu_mhz);
		end
		if (state_q == iclm_pkg::S_MUL2) begin
			w_q <= iclm_pkg::win_t'(prod_q) * iclm_pkg::win_t'(iclm_pkg::KHZ_PER_MHZ);
		end
		if (state_q == iclm_pkg::S_CHECK) begin
			w201_q <= iclm_pkg::num_t'(w_q) * iclm_pkg::num_t'(iclm_pkg::LOAD_BIAS);
		end

		// idle at or above the window caps the fraction at one
		if (state_q == iclm_pkg::S_PREP_IDLE && snap_ge_w) begin
			idle_res_q <= iclm_pkg::IDLE_FULL;
			load_res_q <= iclm_pkg::LOAD_NONE;
		end
		if (state_q == iclm_pkg::S_DIV_IDLE && div_rsp.done) begin
			idle_res_q <= div_rsp.quo;
		end
		if (state_q == iclm_pkg::S_DIV_LOAD && div_rsp.done) begin
			load_res_q <= div_rsp.quo[6:0];
		end

		if (out_load) begin
			out_q.out_core        <= cidx_q[0];
			out_q.load_percent    <= load_res_q;
			out_q.idle_hundredths <= idle_res_q;
			out_q.last            <= last_core;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign cfg_ready = 1'b1;

	// results never leave their ranges
	`ICLM_ASSERT_IMPLIES(a_out_range, out_valid_q,
		out_q.load_percent <= 7'd100 && out_q.idle_hundredths <= 14'd10000,
		"load or idle figure out of range")
	// divider only reports back while the sequencer waits for it
	`ICLM_ASSERT_IMPLIES(a_done_in_wait, div_rsp.done,
		state_q == iclm_pkg::S_DIV_IDLE || state_q == iclm_pkg::S_DIV_LOAD,
		"divider result arrived outside a wait state")
	// an accepted update restarts the window at its own time stamp
	`ICLM_ASSERT_IMPLIES(a_window_restart, state_q == iclm_pkg::S_MUL1,
		wstart_q == in_q.now_ms, "window start not moved to update time")

endmodule

`default_nettype wire
